/* sv/wsd_pkg.sv */
// Shared types and codes for the WebSocket frame deframer.
// Used by wsd_parse and websocket_frame_deframer; depends on nothing.
package wsd_pkg;

	typedef enum logic [2:0] {
		PH_HEAD0  = 3'd0,
		PH_HEAD1  = 3'd1,
		PH_EXT16  = 3'd2,
		PH_EXT64  = 3'd3,
		PH_KEY    = 3'd4,
		PH_DATA   = 3'd5,
		PH_SKIP   = 3'd6,
		PH_CLOSED = 3'd7
	} phase_t;

	localparam logic [1:0] EV_DATA  = 2'd0;
	localparam logic [1:0] EV_PING  = 2'd1;
	localparam logic [1:0] EV_CLOSE = 2'd2;
	localparam logic [1:0] EV_PONG  = 2'd3;

	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	localparam logic [6:0] LEN7_MAX_SHORT = 7'd125;
	localparam logic [6:0] LEN7_EXT16     = 7'd126;

	localparam int LEN_W = 63;

	// One parsed result, as handed from the parser to the output register.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [1:0] kind;
		logic [1:0] opcode;
		logic       fin;
		logic       last;
	} wsd_result_t;

endpackage

/* sv/wsd_parse.sv */
// Frame header parser and payload unmasker: holds the frame state and
// advances it by one byte per step. Depends on wsd_pkg.
module wsd_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         in_byte,
	output wsd_pkg::wsd_result_t res
);
	import wsd_pkg::*;

	phase_t             phase_q, phase_d;
	logic [2:0]         cnt_q, cnt_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [31:0]        key_q, key_d;
	logic [1:0]         idx_q, idx_d;
	logic               masked_q, masked_d;
	logic [3:0]         op_q, op_d;
	logic               fin_q, fin_d;

	logic               len_done;
	logic               begin_pay;
	logic               end_ctl;
	logic               is_data;
	logic [7:0]         key_byte;

	assign is_data  = (op_q <= OP_BINARY);
	assign key_byte = key_q[5'(31 - 8 * int'(idx_q)) -: 8];

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		len_d     = len_q;
		key_d     = key_q;
		idx_d     = idx_q;
		masked_d  = masked_q;
		op_d      = op_q;
		fin_d     = fin_q;
		len_done  = 1'b0;
		begin_pay = 1'b0;
		end_ctl   = 1'b0;
		res       = '0;

		case (phase_q)
			PH_HEAD0: begin
				fin_d   = in_byte[7];
				op_d    = in_byte[3:0];
				phase_d = PH_HEAD1;
			end
			PH_HEAD1: begin
				masked_d = in_byte[7];
				key_d    = '0;
				cnt_d    = '0;
				if (in_byte[6:0] <= LEN7_MAX_SHORT) begin
					len_d    = {{(LEN_W-7){1'b0}}, in_byte[6:0]};
					len_done = 1'b1;
				end else begin
					len_d   = '0;
					phase_d = (in_byte[6:0] == LEN7_EXT16) ? PH_EXT16 : PH_EXT64;
				end
			end
			PH_EXT16, PH_EXT64: begin
				len_d = {len_q[LEN_W-9:0], in_byte};
				cnt_d = cnt_q + 3'd1;
				if ((phase_q == PH_EXT16 && cnt_d == 3'd2) ||
				    (phase_q == PH_EXT64 && cnt_d == 3'd0))
					len_done = 1'b1;
			end
			PH_KEY: begin
				key_d = {key_q[23:0], in_byte};
				cnt_d = cnt_q + 3'd1;
				if (cnt_d == 3'd4) begin
					cnt_d     = '0;
					begin_pay = 1'b1;
				end
			end
			PH_DATA: begin
				idx_d      = idx_q + 2'd1;
				len_d      = len_q - LEN_W'(1);
				res.valid  = 1'b1;
				res.data   = in_byte ^ key_byte;
				res.kind   = EV_DATA;
				res.opcode = op_q[1:0];
				res.fin    = fin_q;
				res.last   = (len_q == LEN_W'(1));
				if (len_q == LEN_W'(1))
					phase_d = PH_HEAD0;
			end
			PH_SKIP: begin
				len_d = len_q - LEN_W'(1);
				if (len_q == LEN_W'(1))
					end_ctl = 1'b1;
			end
			default: begin
			end
		endcase

		// The length is known: a key follows if the frame is masked.
		if (len_done) begin
			if (masked_d) begin
				phase_d = PH_KEY;
				cnt_d   = '0;
			end else begin
				begin_pay = 1'b1;
			end
		end

		if (begin_pay) begin
			idx_d = '0;
			if (len_d == '0) begin
				if (is_data)
					phase_d = PH_HEAD0;
				else
					end_ctl = 1'b1;
			end else begin
				phase_d = is_data ? PH_DATA : PH_SKIP;
			end
		end

		// A control or unknown frame has ended; ping, pong and close report it.
		if (end_ctl) begin
			phase_d = PH_HEAD0;
			res.fin = fin_q;
			case (op_q)
				OP_PING: begin
					res.valid = 1'b1;
					res.kind  = EV_PING;
				end
				OP_PONG: begin
					res.valid = 1'b1;
					res.kind  = EV_PONG;
				end
				OP_CLOSE: begin
					res.valid = 1'b1;
					res.kind  = EV_CLOSE;
					phase_d   = PH_CLOSED;
				end
				default: begin
					res.valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEAD0;
			cnt_q    <= '0;
			len_q    <= '0;
			key_q    <= '0;
			idx_q    <= '0;
			masked_q <= 1'b0;
			op_q     <= '0;
			fin_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			len_q    <= len_d;
			key_q    <= key_d;
			idx_q    <= idx_d;
			masked_q <= masked_d;
			op_q     <= op_d;
			fin_q    <= fin_d;
		end
	end

endmodule

/* sv/websocket_frame_deframer.sv */
// Top level of the WebSocket receive deframer: input register, parser and
// result register with valid/ready handshakes. Depends on wsd_pkg, wsd_parse.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   in      | input     | in_valid / in_ready   | in_byte
//   out     | output    | out_valid / out_ready | out_byte, event_kind,
//           |           |                       | frame_opcode, final_fragment,
//           |           |                       | last_of_frame
//
// Each byte passes from acceptance through the input register and then the
// result register, and a new byte is accepted every cycle while out_ready does
// not stall. The parser state steps once per byte when that byte leaves the input
// register, which needs the result register to be empty or being drained.
// Reset clears the frame state to "expecting the first header byte" and
// empties both registers. A stall on out_ready holds the result and, once the
// input register is also full, drops in_ready until the result is taken.
module websocket_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] event_kind,
	output logic [1:0] frame_opcode,
	output logic       final_fragment,
	output logic       last_of_frame
);
	import wsd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	wsd_result_t res;
	wsd_result_t out_q;

	// The byte in the input register moves on when the result register can
	// take whatever it produces, even if it produces nothing.
	assign advance  = valid_s1 && (!out_q.valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= in_byte;
	end

	wsd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.in_byte (byte_s1),
		.res     (res)
	);

	// The whole result moves in together; a drained register just drops valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance) begin
			out_q <= res;
		end else if (out_ready) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_valid      = out_q.valid;
	assign out_byte       = out_q.data;
	assign event_kind     = out_q.kind;
	assign frame_opcode   = out_q.opcode;
	assign final_fragment = out_q.fin;
	assign last_of_frame  = out_q.last;

endmodule

/* dv/tb_websocket_frame_deframer.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the WebSocket receive deframer.
// Depends on wsd_pkg and on the websocket_frame_deframer RTL.

import wsd_pkg::*;

// One predicted item on the result channel.
typedef struct {
	logic [7:0] data;
	logic [1:0] kind;
	logic [1:0] opcode;
	logic       fin;
	logic       last;
} deframe_result_t;

// Tracks the frame parser state and keeps the results still owed by the block.
class deframe_scoreboard;
	phase_t          phase;
	logic [2:0]      hdr_count;
	logic [62:0]     bytes_left;
	logic [31:0]     key;
	logic [1:0]      key_idx;
	logic            masked;
	logic [3:0]      opcode;
	logic            fin;
	deframe_result_t owed[$];
	int              errors;

	function new();
		phase = PH_HEAD0;
		hdr_count = '0;
		bytes_left = '0;
		key = '0;
		key_idx = '0;
		masked = 1'b0;
		opcode = '0;
		fin = 1'b0;
		errors = 0;
	endfunction

	function void owe(logic [7:0] data, logic [1:0] kind, logic [1:0] op, logic last);
		deframe_result_t r;
		r.data = data;
		r.kind = kind;
		r.opcode = op;
		r.fin = fin;
		r.last = last;
		owed.push_back(r);
	endfunction

	// A control or unknown frame has run out; ping, pong and close report it.
	function void end_control_frame();
		phase = PH_HEAD0;
		case (opcode)
			OP_PING: owe(8'h00, EV_PING, 2'b00, 1'b0);
			OP_PONG: owe(8'h00, EV_PONG, 2'b00, 1'b0);
			OP_CLOSE: begin
				phase = PH_CLOSED;
				owe(8'h00, EV_CLOSE, 2'b00, 1'b0);
			end
			default: ;
		endcase
	endfunction

	function void start_payload();
		key_idx = '0;
		if (bytes_left == '0) begin
			if (opcode <= OP_BINARY)
				phase = PH_HEAD0;
			else
				end_control_frame();
		end else begin
			phase = (opcode <= OP_BINARY) ? PH_DATA : PH_SKIP;
		end
	endfunction

	function void length_known();
		if (masked) begin
			phase = PH_KEY;
			hdr_count = '0;
		end else begin
			start_payload();
		end
	endfunction

	// Advances the parser by one accepted byte.
	function void note_byte(logic [7:0] b);
		logic [7:0] key_byte;
		logic       last;
		case (phase)
			PH_HEAD0: begin
				fin = b[7];
				opcode = b[3:0];
				phase = PH_HEAD1;
			end
			PH_HEAD1: begin
				masked = b[7];
				key = '0;
				hdr_count = '0;
				bytes_left = '0;
				if (b[6:0] <= LEN7_MAX_SHORT) begin
					bytes_left = 63'(b[6:0]);
					length_known();
				end else begin
					phase = (b[6:0] == LEN7_EXT16) ? PH_EXT16 : PH_EXT64;
				end
			end
			PH_EXT16, PH_EXT64: begin
				bytes_left = {bytes_left[54:0], b};
				hdr_count = hdr_count + 3'd1;
				if ((phase == PH_EXT16 && hdr_count == 3'd2) ||
				    (phase == PH_EXT64 && hdr_count == 3'd0))
					length_known();
			end
			PH_KEY: begin
				key = {key[23:0], b};
				hdr_count = hdr_count + 3'd1;
				if (hdr_count == 3'd4) begin
					hdr_count = '0;
					start_payload();
				end
			end
			PH_DATA: begin
				key_byte = key[31 - 8 * key_idx -: 8];
				key_idx = key_idx + 2'd1;
				bytes_left = bytes_left - 63'd1;
				last = (bytes_left == '0);
				if (last)
					phase = PH_HEAD0;
				owe(b ^ key_byte, EV_DATA, opcode[1:0], last);
			end
			PH_SKIP: begin
				bytes_left = bytes_left - 63'd1;
				if (bytes_left == '0)
					end_control_frame();
			end
			default: ;
		endcase
	endfunction

	function void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(logic [7:0] data, logic [1:0] kind, logic [1:0] op,
				   logic fin_bit, logic last);
		deframe_result_t r;
		if (owed.size() == 0) begin
			$error("result with nothing owed: out_byte %0h event_kind %0h", data, kind);
			errors++;
			return;
		end
		r = owed.pop_front();
		compare_field("out_byte", r.data, data);
		compare_field("event_kind", 8'(r.kind), 8'(kind));
		compare_field("frame_opcode", 8'(r.opcode), 8'(op));
		compare_field("final_fragment", 8'(r.fin), 8'(fin_bit));
		compare_field("last_of_frame", 8'(r.last), 8'(last));
	endfunction
endclass

module tb_websocket_frame_deframer;

	// Opcodes of the framing that the package does not name.
	localparam logic [3:0] OP_CONT = 4'h0;
	localparam logic [3:0] OP_TEXT = 4'h1;

	// Drain pause after the last owed result, past the two pipeline registers.
	localparam int DRAIN_CYCLES = 10;
	localparam int DRAIN_LIMIT  = 20000;
	// Length of the long back-pressure hold on the result channel.
	localparam int HOLD_CYCLES  = 80;
	// Random frames are added until this many bytes have gone in overall.
	localparam int TOTAL_BYTES  = 530;

	// How the payload length of a frame is encoded in its header.
	typedef enum logic [1:0] {
		LEN_SHORT,
		LEN_EXT16,
		LEN_EXT64
	} len_form_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] event_kind;
	logic [1:0] frame_opcode;
	logic       final_fragment;
	logic       last_of_frame;

	deframe_scoreboard sb = new();

	// Sender gaps are read only by the driving tasks; receiver stalls and hold
	// requests are handed to the receiver process through nonblocking writes.
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int bytes_sent = 0;

	websocket_frame_deframer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.event_kind     (event_kind),
		.frame_opcode   (frame_opcode),
		.final_fragment (final_fragment),
		.last_of_frame  (last_of_frame)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver either stalls at random, takes every item, or holds off
	// for a counted stretch when the stimulus asks for back-pressure.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_requests != holds_served) begin
			holds_served++;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (stalls_on) begin
			out_ready <= ($urandom_range(99) >= 36);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Both channels are sampled at the rising edge, before any of this
	// edge's updates land. An input is noted before a result is checked,
	// although a byte's result can never leave in the cycle it is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_byte(in_byte);
			if (out_valid && out_ready)
				sb.check_result(out_byte, event_kind, frame_opcode, final_fragment,
						last_of_frame);
		end
	end

	// Offers one byte and returns once it has been accepted. Valid stays high
	// on return so that back-to-back bytes need no extra assignment.
	task automatic send_byte(input logic [7:0] value);
		while (gaps_on && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Sends one whole frame: header, any extended length, any masking key,
	// then the payload. The RSV bits carry random junk that must be ignored.
	task automatic send_frame(input logic fin_bit, input logic [3:0] op, input logic masked,
				  input int len, input len_form_t form);
		logic [63:0] len64;
		int          k;
		send_byte({fin_bit, 3'($urandom_range(7)), op});
		case (form)
			LEN_SHORT: send_byte({masked, 7'(len)});
			LEN_EXT16: begin
				send_byte({masked, LEN7_EXT16});
				send_byte(8'(len >> 8));
				send_byte(8'(len));
			end
			default: begin
				// The top bit of the 64-bit length is dropped by the block.
				len64 = 64'(len);
				len64[63] = 1'($urandom_range(1));
				send_byte({masked, 7'h7f});
				for (k = 7; k >= 0; k--)
					send_byte(len64[8 * k +: 8]);
			end
		endcase
		if (masked) begin
			for (k = 0; k < 4; k++)
				send_byte(8'($urandom_range(255)));
		end
		// Payload bytes lean toward the two extremes now and then.
		for (k = 0; k < len; k++) begin
			case ($urandom_range(9))
				0: send_byte(8'h00);
				1: send_byte(8'hff);
				default: send_byte(8'($urandom_range(255)));
			endcase
		end
	endtask

	initial begin
		logic [3:0] op;
		int         len;
		int         pick;
		len_form_t  form;
		int         i;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames: each data opcode masked and unmasked, empty data
		// frames, empty and non-empty ping and pong, unknown opcodes, both
		// extended length forms with the dropped top bit, and a ping whose
		// length goes past the 125 that control frames are meant to keep to.
		send_frame(1'b1, OP_TEXT, 1'b0, 3, LEN_SHORT);
		send_frame(1'b0, OP_BINARY, 1'b1, 5, LEN_SHORT);
		send_frame(1'b1, OP_CONT, 1'b1, 1, LEN_SHORT);
		send_frame(1'b1, OP_TEXT, 1'b0, 0, LEN_SHORT);
		send_frame(1'b0, OP_BINARY, 1'b1, 0, LEN_SHORT);
		send_frame(1'b1, OP_PING, 1'b0, 0, LEN_SHORT);
		send_frame(1'b0, OP_PONG, 1'b1, 0, LEN_SHORT);
		send_frame(1'b1, OP_PING, 1'b1, 4, LEN_SHORT);
		send_frame(1'b1, OP_PONG, 1'b0, 2, LEN_SHORT);
		send_frame(1'b0, 4'h3, 1'b0, 2, LEN_SHORT);
		send_frame(1'b1, 4'hf, 1'b1, 0, LEN_SHORT);
		send_frame(1'b1, 4'hb, 1'b0, 1, LEN_SHORT);
		send_frame(1'b1, OP_TEXT, 1'b1, 3, LEN_EXT16);
		send_frame(1'b0, OP_BINARY, 1'b0, 2, LEN_EXT64);
		send_frame(1'b1, OP_PING, 1'b0, 126, LEN_EXT16);
		send_frame(1'b1, OP_CONT, 1'b0, 127, LEN_EXT16);

		// A stretch with no idling on either side.
		gaps_on = 1'b0;
		stalls_on <= 1'b0;
		send_frame(1'b1, OP_BINARY, 1'b1, 40, LEN_SHORT);
		send_frame(1'b1, OP_PONG, 1'b1, 3, LEN_SHORT);
		send_frame(1'b0, OP_TEXT, 1'b0, 30, LEN_SHORT);

		// The receiver holds off while the sender keeps offering a long data
		// frame, so both registers fill and the input stalls.
		hold_requests <= hold_requests + 1;
		send_frame(1'b1, OP_BINARY, 1'b0, 60, LEN_SHORT);

		// Random frames with random content, unknown opcodes included. Close is kept back
		// for the very end since it stops the block until the next reset.
		gaps_on = 1'b1;
		stalls_on <= 1'b1;
		while (bytes_sent < TOTAL_BYTES) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				op = 4'($urandom_range(2));
			end else if (pick < 90) begin
				op = $urandom_range(1) ? OP_PING : OP_PONG;
			end else begin
				do
					op = 4'($urandom_range(15));
				while (op <= OP_BINARY || op == OP_CLOSE || op == OP_PING ||
				       op == OP_PONG);
			end
			pick = $urandom_range(99);
			if (pick < 60)
				len = $urandom_range(8);
			else if (pick < 85)
				len = $urandom_range(40, 9);
			else if (pick < 95)
				len = $urandom_range(125, 41);
			else
				len = $urandom_range(300, 126);
			pick = $urandom_range(99);
			if (len > 125 || (pick >= 80 && pick < 95))
				form = LEN_EXT16;
			else if (pick >= 95)
				form = LEN_EXT64;
			else
				form = LEN_SHORT;
			send_frame(1'($urandom_range(1)), op, 1'($urandom_range(1)), len, form);
		end

		// Close ends the stream; whatever follows it is dropped.
		send_frame(1'($urandom_range(1)), OP_CLOSE, 1'($urandom_range(1)),
			   $urandom_range(3), LEN_SHORT);
		for (i = 0; i < 8; i++)
			send_byte(8'($urandom_range(255)));
		in_valid <= 1'b0;

		for (i = 0; i < DRAIN_LIMIT && sb.owed.size() > 0; i++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.owed.size() > 0) begin
			$error("%0d results still owed at the end of the run", sb.owed.size());
			sb.errors++;
		end

		if (sb.errors == 0)
			$display("** websocket_frame_deframer: PASSED **");
		else
			$display("** websocket_frame_deframer: FAILED **");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("** websocket_frame_deframer: FAILED **");
		$finish;
	end

endmodule
